@@ rtl/scc_pkg.sv @@
// shared types and constants for the scc pair counter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;
    localparam int NODE_W    = 10;   // node index
    localparam int CNT_W     = 11;   // node counts, visit numbers
    localparam int EPTR_W    = 14;   // edge pointer incl. empty marker
    localparam int EIDX_W    = 13;   // edge memory address
    localparam int PAIR_W    = 19;
    localparam int PROD_W    = 21;

    typedef struct packed {
        logic [CNT_W-1:0] source_node;
        logic [CNT_W-1:0] target_node;
        logic             last_edge;
    } scc_in_t;

    typedef struct packed {
        logic [PAIR_W-1:0] pair_count;
        logic [CNT_W-1:0]  component_count;
        logic              edges_dropped;
    } scc_out_t;

    typedef struct packed {
        logic             clear;
        logic             start;
        logic [CNT_W-1:0] size;
    } scc_acc_ctl_t;

endpackage

`default_nettype wire

@@ rtl/scc_pair_counter.sv @@
// an edge word is accepted, range checked and then inserted into its source list
// a last edge adds the component walk over the visited nodes and their stored edges,
// then the result, then a sweep that clears the visit marks
// a new edge word is accepted only in idle, once the last one is inserted
// reset: synchronous active-low aresetn, then a sweep that empties
// the adjacency heads, visit marks and on-stack flags, s_ready low during it
`timescale 1ns / 1ps
`default_nettype none

module scc_pair_counter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration: node count
    input  wire logic              cfg_wr_en,
    input  wire logic [10:0]       cfg_wr_data,
    // edge words in
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire scc_pkg::scc_in_t  s_data,
    // result words out
    output logic                   m_valid,
    input  wire logic              m_ready,
    output scc_pkg::scc_out_t      m_data
);
    import scc_pkg::*;

    logic     core_ready;
    logic     res_valid;
    logic     res_free;
    scc_out_t res_word;

    logic     m_valid_reg, m_valid_next;
    scc_out_t m_data_reg;

    // output register frees when empty or being taken
    assign res_free = !m_valid_reg || m_ready;

    scc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_take     (s_valid && core_ready),
        .in_word     (s_data),
        .in_ready    (core_ready),
        .res_free    (res_free),
        .res_valid   (res_valid),
        .res_word    (res_word)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result word held until taken
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_word;
        end
    end

    assign s_ready = core_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/scc_pair_acc.sv @@
// pair accumulator: adds size*(size-1)/2 per finished component
// depends on scc_pkg
`timescale 1ns / 1ps
`default_nettype none

module scc_pair_acc (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire scc_pkg::scc_acc_ctl_t ctl,
    output logic [scc_pkg::PAIR_W-1:0] pairs
);
    import scc_pkg::*;

    logic              pend_reg, pend_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PAIR_W-1:0] pairs_reg, pairs_next;

    always_comb begin
        pend_next  = ctl.start;
        pairs_next = pairs_reg;
        if (ctl.clear) begin
            pairs_next = '0;
        end else if (pend_reg) begin
            pairs_next = pairs_reg + PAIR_W'(prod_reg >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            pairs_reg <= '0;
        end else begin
            pend_reg  <= pend_next;
            pairs_reg <= pairs_next;
        end
    end

    // product registered before the add
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(ctl.size) * (PROD_W'(ctl.size) - PROD_W'(1));
    end

    assign pairs = pairs_reg;

endmodule

`default_nettype wire

@@ rtl/scc_core.sv @@
// graph store and tarjan search sequencer with its memories
// depends on scc_pkg and scc_pair_acc
`timescale 1ns / 1ps
`default_nettype none

module scc_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [10:0]            cfg_wr_data,
    input  wire logic                   in_take,
    input  wire scc_pkg::scc_in_t       in_word,
    output logic                        in_ready,
    input  wire logic                   res_free,
    output logic                        res_valid,
    output scc_pkg::scc_out_t           res_word
);
    import scc_pkg::*;

    typedef enum logic [22:0] {
        S_INIT     = 23'd1 << 0,
        S_IDLE     = 23'd1 << 1,
        S_ST1      = 23'd1 << 2,
        S_ST2      = 23'd1 << 3,
        S_ROOT     = 23'd1 << 4,
        S_ROOT_CHK = 23'd1 << 5,
        S_ENTER    = 23'd1 << 6,
        S_ENTER2   = 23'd1 << 7,
        S_LOOP     = 23'd1 << 8,
        S_F1       = 23'd1 << 9,
        S_F2       = 23'd1 << 10,
        S_F3       = 23'd1 << 11,
        S_F4       = 23'd1 << 12,
        S_R1       = 23'd1 << 13,
        S_POP      = 23'd1 << 14,
        S_POP2     = 23'd1 << 15,
        S_COMP     = 23'd1 << 16,
        S_COMP_W   = 23'd1 << 17,
        S_RET      = 23'd1 << 18,
        S_RET2     = 23'd1 << 19,
        S_RET3     = 23'd1 << 20,
        S_DONE     = 23'd1 << 21,
        S_CLR      = 23'd1 << 22
    } state_t;

    localparam logic [CNT_W-1:0]  N_MAX = CNT_W'(MAX_NODES);
    localparam logic [EPTR_W-1:0] E_MAX = EPTR_W'(MAX_EDGES);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cfg_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [NODE_W-1:0] clr_reg, clr_next;
    scc_in_t           item_reg;
    logic [EPTR_W-1:0] total_reg, total_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]  comps_reg, comps_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [NODE_W-1:0] x_reg, x_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [NODE_W-1:0] j_reg, j_next;
    logic [NODE_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]  visj_reg, visj_next;
    logic [CNT_W-1:0]  lowu_reg, lowu_next;

    // memories
    logic [EPTR_W-1:0]        head_mem [MAX_NODES];
    logic [2*EPTR_W-5:0]      edge_mem [MAX_EDGES];   // {target, link}
    logic [CNT_W-1:0]         vis_mem  [MAX_NODES];
    logic [CNT_W-1:0]         low_mem  [MAX_NODES];
    logic                     onstk_mem[MAX_NODES];
    logic [NODE_W-1:0]        nstk_mem [MAX_NODES];
    logic [NODE_W+EPTR_W-1:0] frame_mem[MAX_NODES];   // {node, next edge}

    logic                     head_we, edge_we, vis_we, low_we, onstk_we, nstk_we, frame_we;
    logic [NODE_W-1:0]        head_wa, vis_wa, low_wa, onstk_wa, nstk_wa, frame_wa;
    logic [NODE_W-1:0]        head_ra, vis_ra, low_ra, onstk_ra, nstk_ra, frame_ra;
    logic [EIDX_W-1:0]        edge_wa, edge_ra;
    logic [EPTR_W-1:0]        head_wd, head_rd;
    logic [2*EPTR_W-5:0]      edge_wd, edge_rd;
    logic [CNT_W-1:0]         vis_wd, vis_rd, low_wd, low_rd;
    logic                     onstk_wd, onstk_rd;
    logic [NODE_W-1:0]        nstk_wd, nstk_rd;
    logic [NODE_W+EPTR_W-1:0] frame_wd, frame_rd;

    scc_acc_ctl_t      acc_ctl;
    logic [PAIR_W-1:0] pairs;

    logic [NODE_W-1:0] src_idx, fr_node, e_tgt;
    logic [EPTR_W-1:0] fr_edge, e_link;
    logic              edge_ok;

    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (cfg_reg > N_MAX) begin
            n_eff = N_MAX;
        end else begin
            n_eff = cfg_reg;
        end
    end

    assign src_idx = NODE_W'(item_reg.source_node - CNT_W'(1));
    assign fr_node = frame_rd[NODE_W+EPTR_W-1:EPTR_W];
    assign fr_edge = frame_rd[EPTR_W-1:0];
    assign e_tgt   = edge_rd[2*EPTR_W-5:EPTR_W];
    assign e_link  = edge_rd[EPTR_W-1:0];
    assign edge_ok = (item_reg.source_node != '0) && (item_reg.source_node <= n_eff) &&
                     (item_reg.target_node != '0) && (item_reg.target_node <= n_eff) &&
                     (total_reg < E_MAX);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        total_next = total_reg;
        drop_next  = drop_reg;
        r_next     = r_reg;
        depth_next = depth_reg;
        sp_next    = sp_reg;
        vcnt_next  = vcnt_reg;
        comps_next = comps_reg;
        size_next  = size_reg;
        x_next     = x_reg;
        u_next     = u_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        visj_next  = visj_reg;
        lowu_next  = lowu_reg;

        head_we  = 1'b0; head_wa  = src_idx;        head_wd  = total_reg;
        head_ra  = src_idx;
        edge_we  = 1'b0; edge_wa  = total_reg[EIDX_W-1:0];
        edge_wd  = {NODE_W'(item_reg.target_node - CNT_W'(1)), head_rd};
        edge_ra  = fr_edge[EIDX_W-1:0];
        vis_we   = 1'b0; vis_wa   = x_reg;          vis_wd   = vcnt_reg + CNT_W'(1);
        vis_ra   = fr_node;
        low_we   = 1'b0; low_wa   = x_reg;          low_wd   = vcnt_reg + CNT_W'(1);
        low_ra   = fr_node;
        onstk_we = 1'b0; onstk_wa = x_reg;          onstk_wd = 1'b1;
        onstk_ra = j_reg;
        nstk_we  = 1'b0; nstk_wa  = sp_reg[NODE_W-1:0]; nstk_wd = x_reg;
        nstk_ra  = NODE_W'(sp_reg - CNT_W'(1));
        frame_we = 1'b0; frame_wa = depth_reg[NODE_W-1:0];
        frame_wd = {x_reg, head_rd};
        frame_ra = NODE_W'(depth_reg - CNT_W'(1));

        acc_ctl.clear = 1'b0;
        acc_ctl.start = 1'b0;
        acc_ctl.size  = size_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;

        unique case (state_reg)
            S_INIT: begin
                head_we  = 1'b1; head_wa  = clr_reg; head_wd = E_MAX;
                vis_we   = 1'b1; vis_wa   = clr_reg; vis_wd  = '0;
                onstk_we = 1'b1; onstk_wa = clr_reg; onstk_wd = 1'b0;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_take) begin
                    state_next = S_ST1;
                end
            end
            S_ST1: begin
                if (edge_ok) begin
                    state_next = S_ST2;
                end else begin
                    drop_next = 1'b1;
                    if (item_reg.last_edge) begin
                        r_next        = '0;
                        vcnt_next     = '0;
                        comps_next    = '0;
                        acc_ctl.clear = 1'b1;
                        state_next    = S_ROOT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ST2: begin
                // new edge goes to the front of its source list
                edge_we    = 1'b1;
                head_we    = 1'b1;
                total_next = total_reg + EPTR_W'(1);
                if (item_reg.last_edge) begin
                    r_next        = '0;
                    vcnt_next     = '0;
                    comps_next    = '0;
                    acc_ctl.clear = 1'b1;
                    state_next    = S_ROOT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT: begin
                vis_ra = r_reg[NODE_W-1:0];
                if (r_reg < n_eff) begin
                    state_next = S_ROOT_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ROOT_CHK: begin
                if (vis_rd != '0) begin
                    r_next     = r_reg + CNT_W'(1);
                    state_next = S_ROOT;
                end else begin
                    x_next     = r_reg[NODE_W-1:0];
                    state_next = S_ENTER;
                end
            end
            S_ENTER: begin
                vcnt_next = vcnt_reg + CNT_W'(1);
                vis_we    = 1'b1;
                low_we    = 1'b1;
                onstk_we  = 1'b1;
                if (sp_reg < N_MAX) begin
                    nstk_we = 1'b1;
                    sp_next = sp_reg + CNT_W'(1);
                end
                head_ra    = x_reg;
                state_next = S_ENTER2;
            end
            S_ENTER2: begin
                if (depth_reg < N_MAX) begin
                    frame_we   = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                end
                state_next = S_LOOP;
            end
            S_LOOP: begin
                if (depth_reg == '0) begin
                    r_next     = r_reg + CNT_W'(1);
                    state_next = S_ROOT;
                end else begin
                    state_next = S_F1;
                end
            end
            S_F1: begin
                u_next = fr_node;
                if (fr_edge < total_reg) begin
                    state_next = S_F2;
                end else begin
                    state_next = S_R1;
                end
            end
            S_F2: begin
                frame_we = 1'b1;
                frame_wa = NODE_W'(depth_reg - CNT_W'(1));
                frame_wd = {u_reg, e_link};
                vis_ra   = e_tgt;
                j_next   = e_tgt;
                if ({1'b0, e_tgt} >= n_eff || {1'b0, u_reg} >= n_eff) begin
                    state_next = S_LOOP;
                end else begin
                    state_next = S_F3;
                end
            end
            S_F3: begin
                if (vis_rd == '0) begin
                    x_next     = j_reg;
                    state_next = S_ENTER;
                end else begin
                    visj_next  = vis_rd;
                    low_ra     = u_reg;
                    state_next = S_F4;
                end
            end
            S_F4: begin
                if (onstk_rd && (visj_reg < low_rd)) begin
                    low_we = 1'b1;
                    low_wa = u_reg;
                    low_wd = visj_reg;
                end
                state_next = S_LOOP;
            end
            S_R1: begin
                lowu_next = low_rd;
                size_next = '0;
                if (low_rd == vis_rd) begin
                    state_next = S_POP;
                end else begin
                    state_next = S_RET;
                end
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    state_next = S_COMP;
                end else begin
                    sp_next    = sp_reg - CNT_W'(1);
                    state_next = S_POP2;
                end
            end
            S_POP2: begin
                onstk_we  = 1'b1;
                onstk_wa  = nstk_rd;
                onstk_wd  = 1'b0;
                size_next = size_reg + CNT_W'(1);
                if (nstk_rd == u_reg) begin
                    state_next = S_COMP;
                end else begin
                    state_next = S_POP;
                end
            end
            S_COMP: begin
                acc_ctl.start = 1'b1;
                comps_next    = comps_reg + CNT_W'(1);
                state_next    = S_COMP_W;
            end
            S_COMP_W: begin
                state_next = S_RET;
            end
            S_RET: begin
                depth_next = depth_reg - CNT_W'(1);
                frame_ra   = NODE_W'(depth_reg - CNT_W'(2));
                if (depth_reg == CNT_W'(1)) begin
                    state_next = S_LOOP;
                end else begin
                    state_next = S_RET2;
                end
            end
            S_RET2: begin
                p_next     = fr_node;
                low_ra     = fr_node;
                state_next = S_RET3;
            end
            S_RET3: begin
                if (lowu_reg < low_rd) begin
                    low_we = 1'b1;
                    low_wa = p_reg;
                    low_wd = lowu_reg;
                end
                state_next = S_LOOP;
            end
            S_DONE: begin
                if (res_free) begin
                    res_valid  = 1'b1;
                    clr_next   = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR: begin
                vis_we   = 1'b1; vis_wa   = clr_reg; vis_wd   = '0;
                onstk_we = 1'b1; onstk_wa = clr_reg; onstk_wd = 1'b0;
                clr_next = clr_reg + NODE_W'(1);
                sp_next  = '0;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    assign res_word.pair_count      = pairs;
    assign res_word.component_count = comps_reg;
    assign res_word.edges_dropped   = drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cfg_reg   <= CNT_W'(1);
            clr_reg   <= '0;
            total_reg <= '0;
            drop_reg  <= 1'b0;
            r_reg     <= '0;
            depth_reg <= '0;
            sp_reg    <= '0;
            vcnt_reg  <= '0;
            comps_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            clr_reg   <= clr_next;
            total_reg <= total_next;
            drop_reg  <= drop_next;
            r_reg     <= r_next;
            depth_reg <= depth_next;
            sp_reg    <= sp_next;
            vcnt_reg  <= vcnt_next;
            comps_reg <= comps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && state_reg == S_IDLE) begin
            item_reg <= in_word;
        end
        size_reg <= size_next;
        x_reg    <= x_next;
        u_reg    <= u_next;
        j_reg    <= j_next;
        p_reg    <= p_next;
        visj_reg <= visj_next;
        lowu_reg <= lowu_next;
    end

    // memory ports: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
    end
    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_wa] <= edge_wd;
        edge_rd <= edge_mem[edge_ra];
    end
    always_ff @(posedge aclk) begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_rd <= vis_mem[vis_ra];
    end
    always_ff @(posedge aclk) begin
        if (low_we) low_mem[low_wa] <= low_wd;
        low_rd <= low_mem[low_ra];
    end
    always_ff @(posedge aclk) begin
        if (onstk_we) onstk_mem[onstk_wa] <= onstk_wd;
        onstk_rd <= onstk_mem[onstk_ra];
    end
    always_ff @(posedge aclk) begin
        if (nstk_we) nstk_mem[nstk_wa] <= nstk_wd;
        nstk_rd <= nstk_mem[nstk_ra];
    end
    always_ff @(posedge aclk) begin
        if (frame_we) frame_mem[frame_wa] <= frame_wd;
        frame_rd <= frame_mem[frame_ra];
    end

    scc_pair_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .pairs   (pairs)
    );

endmodule

`default_nettype wire
